// File: design/dswrap_pkg.sv
// shared types, constants and helpers for the dictionary spell check and wrap block
// no dependencies
package dswrap_pkg;

  // register indexes on the configuration channel
  localparam logic [7:0] CFG_LINE_WIDTH   = 8'd0;
  localparam logic [7:0] CFG_MARKUP_EXTRA = 8'd1;

  // register reset values
  localparam logic [7:0] LINE_WIDTH_RST   = 8'd80;
  localparam logic [4:0] MARKUP_EXTRA_RST = 5'd11;

  // saturation limit of the printed width field
  localparam logic [6:0] PRINTED_MAX = 7'd63;

  // control flags that travel with each character down the cell chain
  typedef struct packed {
    logic valid;    // slot holds a character
    logic text;     // text character, else dictionary character
    logic last;     // closes the word
    logic active;   // position below the maximum word length
    logic wr_char;  // dictionary character to store in the target cell
    logic wr_len;   // dictionary word end, store length in the target cell
    logic trunc;    // word has dropped characters so far
    logic ovf;      // some dictionary word dropped so far
    logic found;    // match collected along the chain
  } tok_flags_t;

  // ascii case folding, only A-Z map to a-z
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// File: design/dswrap_front.sv
// front stage: word position, dictionary fill count and sticky flags
// depends on dswrap_pkg
module dswrap_front import dswrap_pkg::*; #(
  parameter int MAX_LEN    = 30,
  parameter int DICT_WORDS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            take,
  input  logic                            kind,
  input  logic [7:0]                      symbol,
  input  logic                            last,
  output tok_flags_t                      flags,
  output logic [7:0]                      sym,
  output logic [$clog2(MAX_LEN+1)-1:0]    pos,
  output logic [$clog2(MAX_LEN+1)-1:0]    len,
  output logic [$clog2(DICT_WORDS+1)-1:0] count
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(DICT_WORDS + 1);

  logic [LW-1:0] word_pos;
  logic [CW-1:0] dict_count;
  logic          overflow_seen;
  logic          word_trunc;

  logic          active;
  logic          full;
  logic [LW-1:0] len_now;
  logic          trunc_now;
  logic          ovf_now;

  assign active    = word_pos < LW'(MAX_LEN);
  assign full      = dict_count == CW'(DICT_WORDS);
  assign len_now   = active ? word_pos + LW'(1) : word_pos;
  assign trunc_now = word_trunc | ~active;
  assign ovf_now   = overflow_seen | (last & ~kind & full);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_pos      <= '0;
      dict_count    <= '0;
      overflow_seen <= 1'b0;
      word_trunc    <= 1'b0;
      flags         <= '0;
    end else if (en) begin
      flags.valid   <= take;
      flags.text    <= kind;
      flags.last    <= last;
      flags.active  <= active;
      flags.wr_char <= ~kind & active & ~full;
      flags.wr_len  <= last & ~kind & ~full;
      flags.trunc   <= trunc_now;
      flags.ovf     <= ovf_now;
      flags.found   <= 1'b0;
      if (take) begin
        overflow_seen <= ovf_now;
        if (last) begin
          word_pos   <= '0;
          word_trunc <= 1'b0;
          if (~kind && ~full) begin
            dict_count <= dict_count + CW'(1);
          end
        end else begin
          word_pos   <= len_now;
          word_trunc <= trunc_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sym   <= symbol;
      pos   <= word_pos;
      len   <= len_now;
      count <= dict_count;
    end
  end

`ifndef SYNTHESIS
  a_trunc_at_max: assert property (@(posedge clk) disable iff (rst)
    word_trunc |-> word_pos == LW'(MAX_LEN))
    else $error("truncation flag set below the maximum word length");

  a_ovf_when_full: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> dict_count == CW'(DICT_WORDS))
    else $error("dictionary overflow seen while slots remain");
`endif

endmodule

// File: design/dswrap_cell.sv
// one dictionary slot of the compare chain, plus its pipeline stage
// depends on dswrap_pkg
module dswrap_cell import dswrap_pkg::*; #(
  parameter int MAX_LEN    = 30,
  parameter int DICT_WORDS = 64,
  parameter int IDX        = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  tok_flags_t                      flags_in,
  input  logic [7:0]                      sym_in,
  input  logic [$clog2(MAX_LEN+1)-1:0]    pos_in,
  input  logic [$clog2(MAX_LEN+1)-1:0]    len_in,
  input  logic [$clog2(DICT_WORDS+1)-1:0] count_in,
  output tok_flags_t                      flags_out,
  output logic [7:0]                      sym_out,
  output logic [$clog2(MAX_LEN+1)-1:0]    pos_out,
  output logic [$clog2(MAX_LEN+1)-1:0]    len_out,
  output logic [$clog2(DICT_WORDS+1)-1:0] count_out
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(DICT_WORDS + 1);
  localparam int PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [7:0]    chars [MAX_LEN];
  logic [LW-1:0] length;
  logic          match;

  logic [PW-1:0] pos_idx;
  logic          hit;
  logic          match_new;
  logic          mine;
  logic          stored;
  logic          found_here;
  tok_flags_t    flags_next;

  assign pos_idx    = pos_in[PW-1:0];
  assign hit        = (pos_in < length) && (fold(chars[pos_idx]) == fold(sym_in));
  assign match_new  = (flags_in.active & flags_in.text) ? (match & hit) : match;
  assign mine       = count_in == CW'(IDX);
  assign stored     = CW'(IDX) < count_in;
  assign found_here = flags_in.valid & flags_in.last & flags_in.text & stored &
                      match_new & (length == len_in);

  always_comb begin
    flags_next       = flags_in;
    flags_next.found = flags_in.found | found_here;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match     <= 1'b1;
      flags_out <= '0;
    end else if (en) begin
      flags_out <= flags_next;
      if (flags_in.valid) begin
        // every word end rearms the match bit
        match <= flags_in.last ? 1'b1 : match_new;
      end
    end
  end

  // slot storage and stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      sym_out   <= sym_in;
      pos_out   <= pos_in;
      len_out   <= len_in;
      count_out <= count_in;
      if (flags_in.valid && flags_in.wr_char && mine) begin
        chars[pos_idx] <= sym_in;
      end
      if (flags_in.valid && flags_in.wr_len && mine) begin
        length <= len_in;
      end
    end
  end

endmodule

// File: design/dswrap_tail.sv
// tail stage: printed width, greedy line wrap and the result register
// depends on dswrap_pkg
module dswrap_tail import dswrap_pkg::*; #(
  parameter int MAX_LEN = 30
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  tok_flags_t                   flags,
  input  logic [$clog2(MAX_LEN+1)-1:0] len,
  input  logic [7:0]                   line_width,
  input  logic [4:0]                   markup_extra,
  output logic                         out_valid,
  output logic                         found,
  output logic                         break_before,
  output logic [5:0]                   printed_width,
  output logic [7:0]                   column,
  output logic                         truncated,
  output logic                         dict_overflow
);

  logic [7:0] row_used;
  logic       first_word;

  logic       res;
  logic [6:0] width;
  logic [9:0] sum;
  logic       brk;
  logic [7:0] row_next;

  assign res      = flags.valid & flags.last & flags.text;
  assign width    = 7'(len) + (flags.found ? 7'd0 : 7'(markup_extra));
  assign sum      = 10'(row_used) + 10'(width) + 10'd1;
  assign brk      = ~first_word && (sum > 10'(line_width));
  assign row_next = (first_word || brk) ? 8'(width) : sum[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      row_used   <= '0;
      first_word <= 1'b1;
    end else if (en) begin
      out_valid <= res;
      if (res) begin
        row_used   <= row_next;
        first_word <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && res) begin
      found         <= flags.found;
      break_before  <= brk;
      printed_width <= (width > PRINTED_MAX) ? 6'(PRINTED_MAX) : width[5:0];
      column        <= row_next;
      truncated     <= flags.trunc;
      dict_overflow <= flags.ovf;
    end
  end

`ifndef SYNTHESIS
  a_first_no_break: assert property (@(posedge clk) disable iff (rst)
    (en && res && first_word) |=> !break_before)
    else $error("first text word reported a line break");

  a_break_column: assert property (@(posedge clk) disable iff (rst)
    (out_valid && break_before && printed_width != 6'(PRINTED_MAX))
      |-> column == 8'(printed_width))
    else $error("column after a break differs from the printed width");
`endif

endmodule

// File: design/dictionary_spellcheck_wrap_top.sv
// top level of the dictionary spell check and line wrap block
// depends on dswrap_pkg, dswrap_front, dswrap_cell, dswrap_tail
// path: a character accepted by the front stage passes the front register, then each cell
//   register in turn, then the tail result register
// throughput: one character per cycle while no result is stuck at the output, else the whole chain holds
// reset: synchronous rst clears counts and flags and rearms match bits at once; slot contents
//   and lengths are not cleared and no sweep is needed, registers return to 80 and 11
module dictionary_spellcheck_wrap_top import dswrap_pkg::*; #(
  parameter int MAX_LEN    = 30,
  parameter int DICT_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input character stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tlast,   // last: closes the word
  input  logic        s_tuser,   // [0] kind: 0 dictionary, 1 text
  // result stream, one transaction per text word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] found, [1] break_before, [7:2] printed_width,
                                 // [15:8] column, [16] truncated, [17] dict_overflow,
                                 // [23:18] zero
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(DICT_WORDS + 1);

  // configuration registers
  logic [7:0] line_width;
  logic [4:0] markup_extra;

  // whole chain moves together unless a result is stuck at the output
  logic en;
  logic take;

  // chain links, entry 0 is the front stage output
  tok_flags_t    chain_flags [DICT_WORDS+1];
  logic [7:0]    chain_sym   [DICT_WORDS+1];
  logic [LW-1:0] chain_pos   [DICT_WORDS+1];
  logic [LW-1:0] chain_len   [DICT_WORDS+1];
  logic [CW-1:0] chain_count [DICT_WORDS+1];

  // result fields
  logic       r_found;
  logic       r_break;
  logic [5:0] r_printed;
  logic [7:0] r_column;
  logic       r_trunc;
  logic       r_ovf;

  assign en        = ~m_tvalid | m_tready;
  assign s_tready  = en;
  assign take      = s_tvalid & en;
  assign cfg_ready = 1'b1;

  // register writes, indexes outside the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RST;
      markup_extra <= MARKUP_EXTRA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LINE_WIDTH:   line_width   <= cfg_data;
        CFG_MARKUP_EXTRA: markup_extra <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // word position, slot selection and sticky flags
  dswrap_front #(
    .MAX_LEN    (MAX_LEN),
    .DICT_WORDS (DICT_WORDS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .take   (take),
    .kind   (s_tuser),
    .symbol (s_tdata),
    .last   (s_tlast),
    .flags  (chain_flags[0]),
    .sym    (chain_sym[0]),
    .pos    (chain_pos[0]),
    .len    (chain_len[0]),
    .count  (chain_count[0])
  );

  // one cell per dictionary slot; each character visits the slots in turn,
  // so every slot sees writes and compares in arrival order
  for (genvar i = 0; i < DICT_WORDS; i++) begin : g_cell
    dswrap_cell #(
      .MAX_LEN    (MAX_LEN),
      .DICT_WORDS (DICT_WORDS),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .flags_in  (chain_flags[i]),
      .sym_in    (chain_sym[i]),
      .pos_in    (chain_pos[i]),
      .len_in    (chain_len[i]),
      .count_in  (chain_count[i]),
      .flags_out (chain_flags[i+1]),
      .sym_out   (chain_sym[i+1]),
      .pos_out   (chain_pos[i+1]),
      .len_out   (chain_len[i+1]),
      .count_out (chain_count[i+1])
    );
  end

  // width, wrap decision and result register
  dswrap_tail #(
    .MAX_LEN (MAX_LEN)
  ) u_tail (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .flags         (chain_flags[DICT_WORDS]),
    .len           (chain_len[DICT_WORDS]),
    .line_width    (line_width),
    .markup_extra  (markup_extra),
    .out_valid     (m_tvalid),
    .found         (r_found),
    .break_before  (r_break),
    .printed_width (r_printed),
    .column        (r_column),
    .truncated     (r_trunc),
    .dict_overflow (r_ovf)
  );

  assign m_tdata = {6'b0, r_ovf, r_trunc, r_column, r_printed, r_break, r_found};

endmodule
